### hw/rtl/ffsa_pkg.sv
// Shared types and codes for the first-fit segment allocator.
package ffsa_pkg;

  // Request type codes
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // Fixed field widths
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned SEG_W  = 4;
  localparam int unsigned ADDR_W = 12;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SLOT  = 2'd1,
    STATUS_NO_SPACE = 2'd2,
    STATUS_UNOWNED  = 2'd3
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EVAL = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

endpackage

### hw/rtl/first_fit_segment_allocator_top.sv
// First-fit segment allocator: descriptor table, slot scanner and request sequencer.
// Free, unknown and out-of-heap lookup: the sequencer goes straight to hold, then loads the output.
// Lookup: one scan of all slots, then evaluate, then a load of the output register.
// Allocate: 1 to 2*SLOT_COUNT-1 passes, each a scan of all slots at one slot compare per cycle
// plus evaluate, then a load of the output register. Ready returns together with the loaded result,
// and a full output register holds the sequencer. Reset clears all busy marks at once.
module first_fit_segment_allocator_top #(
  parameter int unsigned HEAP_BYTES = 4096,
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [ffsa_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [ffsa_pkg::SEG_W-1:0]    req_segment_i,
  input  logic [ffsa_pkg::ADDR_W-1:0]   req_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ffsa_pkg::SEG_W-1:0]    segment_slot_o,
  output logic [ffsa_pkg::ADDR_W-1:0]   segment_base_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned PW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned BW = $clog2(HEAP_BYTES);
  localparam int unsigned EW = ((PW > ffsa_pkg::SIZE_W) ? PW : ffsa_pkg::SIZE_W) + 1;
  localparam int unsigned XW = ((SW > ffsa_pkg::SEG_W) ? SW : ffsa_pkg::SEG_W) + 2;
  localparam logic [EW-1:0] HEAP_E = EW'(HEAP_BYTES);
  localparam logic [PW-1:0] HEAP_P = PW'(HEAP_BYTES);
  localparam logic [SW:0]   SLOTS_C = (SW + 1)'(SLOT_COUNT);
  localparam logic [XW-1:0] SLOTS_X = XW'(SLOT_COUNT);

  // Descriptor memories and busy marks; entries of clear slots are ignored
  logic [BW-1:0]              base_mem [SLOT_COUNT];
  logic [ffsa_pkg::SIZE_W-1:0] len_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]      busy_q, busy_d;
  logic [BW-1:0]              rd_base_q;
  logic [ffsa_pkg::SIZE_W-1:0] rd_len_q;
  logic                       mem_we;
  logic [SW-1:0]              mem_waddr;

  // Sequencer and scan state
  ffsa_pkg::state_e state_q, state_d;
  logic                 mode_alloc_q, mode_alloc_d;
  logic [ffsa_pkg::SIZE_W-1:0] size_q, size_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [SW:0]          scan_idx_q, scan_idx_d;
  logic                 p_valid_q, p_valid_d;
  logic [SW-1:0]        p_idx_q, p_idx_d;
  logic                 cov_found_q, cov_found_d;
  logic [SW-1:0]        cov_slot_q, cov_slot_d;
  logic [PW-1:0]        cov_end_q, cov_end_d;
  logic [BW-1:0]        cov_base_q, cov_base_d;
  logic [PW-1:0]        nb_q, nb_d;
  logic                 free_found_q, free_found_d;
  logic [SW-1:0]        free_slot_q, free_slot_d;
  logic                 start_scan;

  // Pending result and output register
  ffsa_pkg::status_e    res_status_q, res_status_d;
  logic [ffsa_pkg::SEG_W-1:0]  res_slot_q, res_slot_d;
  logic [ffsa_pkg::ADDR_W-1:0] res_base_q, res_base_d;
  logic                 out_valid_q, out_valid_d;
  ffsa_pkg::status_e    out_status_q;
  logic [ffsa_pkg::SEG_W-1:0]  out_slot_q;
  logic [ffsa_pkg::ADDR_W-1:0] out_base_q;
  logic                 out_load;

  // Shared slot compare unit
  logic          slot_busy;
  logic [EW-1:0] base_e, end_e, pos_e;
  logic          hit, above, free_hit;
  logic [PW-1:0] gap;

  assign slot_busy = busy_q[p_idx_q];
  assign base_e    = EW'(rd_base_q);
  assign end_e     = base_e + EW'(rd_len_q);
  assign pos_e     = EW'(pos_q);
  assign hit       = p_valid_q && slot_busy && (base_e <= pos_e) && (end_e > pos_e);
  assign above     = p_valid_q && slot_busy && (base_e > pos_e) && (base_e < EW'(nb_q));
  assign free_hit  = p_valid_q && !slot_busy && !free_found_q;
  assign gap       = nb_q - pos_q;

  assign in_ready_o     = (state_q == ffsa_pkg::S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign segment_slot_o = out_slot_q;
  assign segment_base_o = out_base_q;

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    mode_alloc_d = mode_alloc_q;
    size_d       = size_q;
    pos_d        = pos_q;
    scan_idx_d   = scan_idx_q;
    p_valid_d    = 1'b0;
    p_idx_d      = p_idx_q;
    cov_found_d  = cov_found_q;
    cov_slot_d   = cov_slot_q;
    cov_end_d    = cov_end_q;
    cov_base_d   = cov_base_q;
    nb_d         = nb_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    busy_d       = busy_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_base_d   = res_base_q;
    start_scan   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = free_slot_q;
    out_load     = 1'b0;

    unique case (state_q)
      ffsa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ffsa_pkg::STATUS_OK;
          res_slot_d   = '0;
          res_base_d   = '0;
          size_d       = req_size_i;
          priority if (req_type_i == ffsa_pkg::REQ_ALLOC) begin
            mode_alloc_d = 1'b1;
            pos_d        = '0;
            start_scan   = 1'b1;
            state_d      = ffsa_pkg::S_SCAN;
          end else if (req_type_i == ffsa_pkg::REQ_LOOKUP) begin
            mode_alloc_d = 1'b0;
            if (EW'(req_address_i) >= HEAP_E) begin
              res_status_d = ffsa_pkg::STATUS_UNOWNED;
              state_d      = ffsa_pkg::S_HOLD;
            end else begin
              pos_d      = PW'(req_address_i);
              start_scan = 1'b1;
              state_d    = ffsa_pkg::S_SCAN;
            end
          end else begin
            // free, or unknown type: status ok, zeros
            if (req_type_i == ffsa_pkg::REQ_FREE &&
                XW'(req_segment_i) < SLOTS_X) begin
              busy_d[SW'(req_segment_i)] = 1'b0;
            end
            state_d = ffsa_pkg::S_HOLD;
          end
        end
      end

      ffsa_pkg::S_SCAN: begin
        // issue next read; evaluate the entry read last cycle
        if (scan_idx_q < SLOTS_C) begin
          p_valid_d  = 1'b1;
          p_idx_d    = scan_idx_q[SW-1:0];
          scan_idx_d = scan_idx_q + 1'b1;
        end else if (!p_valid_q) begin
          state_d = ffsa_pkg::S_EVAL;
        end
        if (hit && !cov_found_q) begin
          cov_found_d = 1'b1;
          cov_slot_d  = p_idx_q;
          cov_end_d   = PW'(end_e);
          cov_base_d  = rd_base_q;
        end
        if (above) begin
          nb_d = PW'(base_e);
        end
        if (free_hit) begin
          free_found_d = 1'b1;
          free_slot_d  = p_idx_q;
        end
      end

      ffsa_pkg::S_EVAL: begin
        state_d = ffsa_pkg::S_HOLD;
        if (!mode_alloc_q) begin
          if (cov_found_q) begin
            res_slot_d = ffsa_pkg::SEG_W'(cov_slot_q);
            res_base_d = ffsa_pkg::ADDR_W'(cov_base_q);
          end else begin
            res_status_d = ffsa_pkg::STATUS_UNOWNED;
          end
        end else if (!free_found_q) begin
          res_status_d = ffsa_pkg::STATUS_NO_SLOT;
        end else if (size_q == '0 || EW'(size_q) > HEAP_E) begin
          res_status_d = ffsa_pkg::STATUS_NO_SPACE;
        end else if (cov_found_q) begin
          // position lies in a busy segment: jump past it
          if (cov_end_q >= HEAP_P) begin
            res_status_d = ffsa_pkg::STATUS_NO_SPACE;
          end else begin
            pos_d      = cov_end_q;
            start_scan = 1'b1;
            state_d    = ffsa_pkg::S_SCAN;
          end
        end else if (EW'(gap) >= EW'(size_q)) begin
          // free run up to the next busy base fits
          mem_we                = 1'b1;
          busy_d[free_slot_q]   = 1'b1;
          res_slot_d            = ffsa_pkg::SEG_W'(free_slot_q);
          res_base_d            = ffsa_pkg::ADDR_W'(pos_q);
        end else if (nb_q >= HEAP_P) begin
          res_status_d = ffsa_pkg::STATUS_NO_SPACE;
        end else begin
          pos_d      = nb_q;
          start_scan = 1'b1;
          state_d    = ffsa_pkg::S_SCAN;
        end
      end

      ffsa_pkg::S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ffsa_pkg::S_IDLE;
        end
      end

      default: state_d = ffsa_pkg::S_IDLE;
    endcase

    // clear scan trackers at the start of every pass
    if (start_scan) begin
      scan_idx_d   = '0;
      p_valid_d    = 1'b0;
      cov_found_d  = 1'b0;
      nb_d         = HEAP_P;
      free_found_d = 1'b0;
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffsa_pkg::S_IDLE;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      p_valid_q   <= 1'b0;
      scan_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      p_valid_q   <= p_valid_d;
      scan_idx_q  <= scan_idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mode_alloc_q <= mode_alloc_d;
    size_q       <= size_d;
    pos_q        <= pos_d;
    p_idx_q      <= p_idx_d;
    cov_found_q  <= cov_found_d;
    cov_slot_q   <= cov_slot_d;
    cov_end_q    <= cov_end_d;
    cov_base_q   <= cov_base_d;
    nb_q         <= nb_d;
    free_found_q <= free_found_d;
    free_slot_q  <= free_slot_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_base_q   <= res_base_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_base_q   <= res_base_q;
    end
  end

  // Descriptor memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      base_mem[mem_waddr] <= BW'(pos_q);
      len_mem[mem_waddr]  <= size_q;
    end
    rd_base_q <= base_mem[scan_idx_q[SW-1:0]];
    rd_len_q  <= len_mem[scan_idx_q[SW-1:0]];
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the first-fit segment allocator: random requests, shadow table.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned HEAP_SIZE = 4096;
  localparam int unsigned SLOT_CNT = 16;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned RANDOM_REQS = 450;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned BACKPRESSURE_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [ffsa_pkg::SIZE_W-1:0] size;
    logic [ffsa_pkg::SEG_W-1:0]  seg;
    logic [ffsa_pkg::ADDR_W-1:0] addr;
  } seg_req_t;

  typedef struct packed {
    ffsa_pkg::status_e           status;
    logic [ffsa_pkg::SEG_W-1:0]  slot;
    logic [ffsa_pkg::ADDR_W-1:0] base;
  } seg_reply_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // DUT ports, all inputs known from time zero
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  req_type_i = ffsa_pkg::REQ_ALLOC;
  logic [ffsa_pkg::SIZE_W-1:0] req_size_i = '0;
  logic [ffsa_pkg::SEG_W-1:0]  req_segment_i = '0;
  logic [ffsa_pkg::ADDR_W-1:0] req_address_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [1:0]                  status_o;
  logic [ffsa_pkg::SEG_W-1:0]  segment_slot_o;
  logic [ffsa_pkg::ADDR_W-1:0] segment_base_o;

  first_fit_segment_allocator_top #(
    .HEAP_BYTES(HEAP_SIZE),
    .SLOT_COUNT(SLOT_CNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .req_size_i    (req_size_i),
    .req_segment_i (req_segment_i),
    .req_address_i (req_address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .segment_slot_o(segment_slot_o),
    .segment_base_o(segment_base_o)
  );

  // Shadow descriptor table
  bit          shadow_busy [SLOT_CNT];
  int unsigned shadow_base [SLOT_CNT];
  int unsigned shadow_len  [SLOT_CNT];

  seg_req_t   request_q[$];
  seg_reply_t reply_q[$];
  seg_req_t   cur_req;
  int unsigned accepted_reqs = 0;
  int unsigned total_reqs = 0;
  int unsigned replies_seen = 0;
  int unsigned error_count = 0;

  // Lowest busy slot covering a byte address, -1 if none
  function automatic int owner_of(int unsigned addr);
    for (int s = 0; s < SLOT_CNT; s++) begin
      if (shadow_busy[s] && shadow_base[s] <= addr && shadow_base[s] + shadow_len[s] > addr)
        return s;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the reply it earns
  function automatic seg_reply_t serve_request(seg_req_t r);
    seg_reply_t  rep;
    int          free_slot;
    int          hit;
    int unsigned pos;
    int unsigned run;
    int unsigned run_start;
    bit          found;
    rep = '{status: ffsa_pkg::STATUS_OK, slot: '0, base: '0};
    case (r.kind)
      ffsa_pkg::REQ_ALLOC: begin
        free_slot = -1;
        for (int s = SLOT_CNT - 1; s >= 0; s--) begin
          if (!shadow_busy[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          rep.status = ffsa_pkg::STATUS_NO_SLOT;
        end else begin
          // first fit: walk the heap, jumping over busy segments
          pos = 0;
          run = 0;
          run_start = 0;
          found = 1'b0;
          if (r.size != 0 && r.size <= HEAP_SIZE) begin
            while (pos < HEAP_SIZE && !found) begin
              hit = owner_of(pos);
              if (hit < 0) begin
                if (run == 0) run_start = pos;
                run++;
                pos++;
                if (run == r.size) found = 1'b1;
              end else begin
                pos = shadow_base[hit] + shadow_len[hit];
                run = 0;
              end
            end
          end
          if (found) begin
            shadow_busy[free_slot] = 1'b1;
            shadow_base[free_slot] = run_start;
            shadow_len[free_slot] = r.size;
            rep.slot = free_slot[ffsa_pkg::SEG_W-1:0];
            rep.base = run_start[ffsa_pkg::ADDR_W-1:0];
          end else begin
            rep.status = ffsa_pkg::STATUS_NO_SPACE;
          end
        end
      end
      ffsa_pkg::REQ_FREE: begin
        if (r.seg < SLOT_CNT) shadow_busy[r.seg] = 1'b0;
      end
      ffsa_pkg::REQ_LOOKUP: begin
        hit = (r.addr < HEAP_SIZE) ? owner_of(r.addr) : -1;
        if (hit < 0) begin
          rep.status = ffsa_pkg::STATUS_UNOWNED;
        end else begin
          rep.slot = hit[ffsa_pkg::SEG_W-1:0];
          rep.base = shadow_base[hit][ffsa_pkg::ADDR_W-1:0];
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic seg_req_t make_req(logic [1:0] kind, int unsigned size,
                                        int unsigned seg, int unsigned addr);
    seg_req_t r;
    r.kind = kind;
    r.size = size[ffsa_pkg::SIZE_W-1:0];
    r.seg  = seg[ffsa_pkg::SEG_W-1:0];
    r.addr = addr[ffsa_pkg::ADDR_W-1:0];
    return r;
  endfunction

  // Sender: bursts of transactions separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : sender
    seg_req_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        reply_q.push_back(serve_request(cur_req));
        accepted_reqs++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          item = request_q.pop_front();
          cur_req <= item;
          req_type_i <= item.kind;
          req_size_i <= item.size;
          req_segment_i <= item.seg;
          req_address_i <= item.addr;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off to back the block up
  int unsigned phase_left;
  int unsigned stall_mode;
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      phase_left <= 0;
      stall_mode <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && replies_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= BACKPRESSURE_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= (hold_left == 1);
    end else begin
      if (phase_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        phase_left <= $urandom_range(20, 150);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Result monitor: compare each reply with the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    seg_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        $error("reply with nothing outstanding: status %0d slot %0d base %0d",
               status_o, segment_slot_o, segment_base_o);
        error_count++;
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (segment_slot_o !== want.slot) begin
          $error("segment_slot: expected %0d, got %0d", want.slot, segment_slot_o);
          error_count++;
        end
        if (segment_base_o !== want.base) begin
          $error("segment_base: expected %0d, got %0d", want.base, segment_base_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int unsigned pick;
    int unsigned sz;
    logic [1:0]  kind;
    // empty table, bad sizes, whole heap, heap full
    request_q.push_back(make_req(ffsa_pkg::REQ_LOOKUP, 8191, 15, 0));
    request_q.push_back(make_req(ffsa_pkg::REQ_ALLOC, 0, 0, 4095));
    request_q.push_back(make_req(ffsa_pkg::REQ_ALLOC, 8191, 15, 0));
    request_q.push_back(make_req(ffsa_pkg::REQ_ALLOC, 4096, 0, 0));
    request_q.push_back(make_req(ffsa_pkg::REQ_ALLOC, 1, 0, 0));
    // release slot 0, then release it again while already free
    request_q.push_back(make_req(ffsa_pkg::REQ_FREE, 0, 0, 4095));
    request_q.push_back(make_req(ffsa_pkg::REQ_FREE, 1, 0, 0));
    request_q.push_back(make_req(REQ_UNKNOWN, 4097, 9, 2730));
    // fill every slot and the whole heap, then ask for one more
    for (int s = 0; s < SLOT_CNT; s++)
      request_q.push_back(make_req(ffsa_pkg::REQ_ALLOC, 256, s, s * 256));
    request_q.push_back(make_req(ffsa_pkg::REQ_ALLOC, 1, 0, 0));
    request_q.push_back(make_req(ffsa_pkg::REQ_LOOKUP, 0, 0, 4095));

    // random mix, mostly small segments so the table churns
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = ffsa_pkg::REQ_ALLOC;
      else if (pick < 72) kind = ffsa_pkg::REQ_FREE;
      else if (pick < 96) kind = ffsa_pkg::REQ_LOOKUP;
      else kind = REQ_UNKNOWN;
      pick = $urandom_range(0, 99);
      if (pick < 70) sz = $urandom_range(1, 256);
      else if (pick < 85) sz = $urandom_range(257, 1024);
      else if (pick < 93) sz = $urandom_range(1025, 4096);
      else if (pick < 96) sz = 0;
      else sz = $urandom_range(4097, 8191);
      request_q.push_back(make_req(kind, sz, $urandom_range(0, SLOT_CNT - 1),
                                   $urandom_range(0, HEAP_SIZE - 1)));
    end
    total_reqs = request_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_reqs < total_reqs) @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
